@@ design/crcfc_pkg.sv @@
// Shared constants, types and the CRC-32 byte update for the frame checker.
package crcfc_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned COUNT_W   = 17;
   localparam int unsigned CRC_W     = 32;
   localparam int unsigned SEQ_W     = 16;
   localparam int unsigned LEN_W     = 16;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned RSP_DATA_W = 64;

   localparam logic [COUNT_W-1:0] HDR_BYTES   = 17'd10;
   localparam logic [COUNT_W-1:0] CRC_HDR_END = 17'd6;
   localparam logic [COUNT_W-1:0] COUNT_MAX   = 17'h1FFFF;
   localparam logic [CRC_W-1:0]   CRC_INIT    = 32'hFFFF_FFFF;
   localparam logic [CRC_W-1:0]   CRC_POLY    = 32'hEDB8_8320;

   // Header byte positions
   localparam logic [3:0] POS_TYPE    = 4'd0;
   localparam logic [3:0] POS_SEQ_HI  = 4'd1;
   localparam logic [3:0] POS_SEQ_LO  = 4'd2;
   localparam logic [3:0] POS_LEN_HI  = 4'd3;
   localparam logic [3:0] POS_LEN_LO  = 4'd4;
   localparam logic [3:0] POS_FLAGS   = 4'd5;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_TRUNC    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_CRC_FAIL = 2'd2;

   // Result kinds
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Queue sizing
   localparam int unsigned Q_DEPTH = 4;
   localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
   localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

   // One queued job: an optional data beat and an optional status beat
   typedef struct packed {
      logic                has_data;
      logic [BYTE_W-1:0]   data;
      logic                has_status;
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   frame_type;
      logic [SEQ_W-1:0]    seq_num;
      logic [LEN_W-1:0]    length;
      logic [BYTE_W-1:0]   flags;
   } job_type;

   // Reflected CRC-32 update by one byte
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
      for (int i = 0; i < BYTE_W; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

@@ design/crc32_frame_checker.sv @@
// A byte's results pass through the job queue and then the result stage's output register.
// One byte per cycle while the queue is not full; a user byte that also ends the frame takes
// two result beats. The rate is set by the front end's combinational byte-wide CRC update.
// A four-entry job queue lets the input keep going while the result side stalls.
// Reset (synchronous, active high) empties the queue and starts a new frame.
// Top level of the CRC-32 frame checker.
module crc32_frame_checker
   import crcfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,  // [7:0] rx_byte
   input  logic                  req_tlast,  // end_of_payload
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] user_byte, [15:8] frame_type, [31:16] sequence_res, [47:32] user_length,
   // [55:48] frame_flags, [57:56] check_status, rest zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,  // kind
   output logic                  rsp_tlast   // last_of_run
);

   logic    in_beat;
   logic    push, pop, empty, full;
   job_type push_job, head_job;

   assign req_tready = !full;
   assign in_beat    = req_tvalid && req_tready;

   crcfc_front u_front (
      .clock   (clock),
      .reset   (reset),
      .in_beat (in_beat),
      .in_byte (req_tdata),
      .in_end  (req_tlast),
      .push    (push),
      .job     (push_job)
   );

   crcfc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (empty),
      .full     (full)
   );

   crcfc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .empty     (empty),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_kind  (rsp_tuser),
      .out_last  (rsp_tlast),
      .out_data  (rsp_tdata)
   );

endmodule

@@ design/crcfc_front.sv @@
// Front end: header decode, CRC accumulation and job generation per byte.
module crcfc_front
   import crcfc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_beat,
   input  logic [BYTE_W-1:0] in_byte,
   input  logic              in_end,
   output logic              push,
   output job_type           job
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [CRC_W-1:0]   crc_ff, crc_in;
   logic [CRC_W-1:0]   stored_ff, stored_in;
   logic [BYTE_W-1:0]  type_ff, type_in;
   logic [SEQ_W-1:0]   seq_ff, seq_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [BYTE_W-1:0]  flags_ff, flags_in;

   logic                in_hdr;
   logic                data_pending;
   logic [COUNT_W-1:0]  frame_end_cur;
   logic [COUNT_W-1:0]  frame_end_new;
   logic [CRC_W-1:0]    crc_upd;
   logic [STATUS_W-1:0] status;

   assign in_hdr        = count_ff < HDR_BYTES;
   assign frame_end_cur = HDR_BYTES + {{(COUNT_W-LEN_W){1'b0}}, len_ff};
   assign data_pending  = !in_hdr && (count_ff < frame_end_cur);
   assign crc_upd       = crc_byte(crc_ff, in_byte);
   assign count_in      = (count_ff != COUNT_MAX) ? count_ff + 1'b1 : count_ff;

   // Header capture and CRC update for this byte
   always_comb begin
      type_in   = type_ff;
      seq_in    = seq_ff;
      len_in    = len_ff;
      flags_in  = flags_ff;
      stored_in = stored_ff;
      crc_in    = crc_ff;
      if (in_hdr) begin
         unique case (count_ff[3:0])
            POS_TYPE:   type_in  = in_byte;
            POS_SEQ_HI: seq_in   = {in_byte, seq_ff[BYTE_W-1:0]};
            POS_SEQ_LO: seq_in   = {seq_ff[SEQ_W-1:BYTE_W], in_byte};
            POS_LEN_HI: len_in   = {in_byte, len_ff[BYTE_W-1:0]};
            POS_LEN_LO: len_in   = {len_ff[LEN_W-1:BYTE_W], in_byte};
            POS_FLAGS:  flags_in = in_byte;
            default:    stored_in = {stored_ff[CRC_W-BYTE_W-1:0], in_byte};
         endcase
         if (count_ff < CRC_HDR_END) begin
            crc_in = crc_upd;
         end
      end else if (data_pending) begin
         crc_in = crc_upd;
      end
   end

   // End of frame verdict, from the values after this byte
   assign frame_end_new = HDR_BYTES + {{(COUNT_W-LEN_W){1'b0}}, len_in};
   always_comb begin
      priority if (count_in < frame_end_new) begin
         status = ST_TRUNC;
      end else if ((crc_in ^ CRC_INIT) != stored_in) begin
         status = ST_CRC_FAIL;
      end else begin
         status = ST_OK;
      end
   end

   assign push           = in_beat && (data_pending || in_end);
   assign job.has_data   = data_pending;
   assign job.data       = in_byte;
   assign job.has_status = in_end;
   assign job.status     = status;
   assign job.frame_type = type_in;
   assign job.seq_num    = seq_in;
   assign job.length     = len_in;
   assign job.flags      = flags_in;

   // Frame state; cleared after each status
   always_ff @(posedge clock) begin
      if (reset || (in_beat && in_end)) begin
         count_ff  <= '0;
         crc_ff    <= CRC_INIT;
         stored_ff <= '0;
         type_ff   <= '0;
         seq_ff    <= '0;
         len_ff    <= '0;
         flags_ff  <= '0;
      end else if (in_beat) begin
         count_ff  <= count_in;
         crc_ff    <= crc_in;
         stored_ff <= stored_in;
         type_ff   <= type_in;
         seq_ff    <= seq_in;
         len_ff    <= len_in;
         flags_ff  <= flags_in;
      end
   end

endmodule

@@ design/crcfc_queue.sv @@
// Short job queue between the front end and the result stage.
module crcfc_queue
   import crcfc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head_job,
   output logic    empty,
   output logic    full
);

   job_type           slot_ff [Q_DEPTH];
   logic [Q_AW-1:0]   wr_ff, rd_ff;
   logic [Q_CW-1:0]   count_ff;
   logic              do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == Q_CW'(Q_DEPTH));
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = slot_ff[rd_ff];

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop)  rd_ff <= rd_ff + 1'b1;
         unique case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_job;
   end

endmodule

@@ design/crcfc_back.sv @@
// Result stage: turns each job into one or two output beats.
module crcfc_back
   import crcfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  job_type               head_job,
   input  logic                  empty,
   output logic                  pop,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic                  out_kind,
   output logic                  out_last,
   output logic [RSP_DATA_W-1:0] out_data
);

   logic    valid_ff;
   logic    phase_ff;   // 1: status beat of a two-beat job
   job_type hold_ff;

   logic    data_beat;
   logic    need_status;
   logic    free;

   assign data_beat   = !phase_ff && hold_ff.has_data;
   assign need_status = data_beat && hold_ff.has_status;
   assign free        = !valid_ff || (out_ready && !need_status);
   assign pop         = free && !empty;

   // Output register and beat phase
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else if (valid_ff && out_ready && need_status) begin
         phase_ff <= 1'b1;
      end else if (free) begin
         valid_ff <= !empty;
         phase_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) hold_ff <= head_job;
   end

   // Beat formatting
   assign out_valid = valid_ff;
   assign out_kind  = data_beat ? KIND_DATA : KIND_STATUS;
   assign out_last  = !need_status;
   always_comb begin
      out_data = '0;
      if (data_beat) begin
         out_data[7:0] = hold_ff.data;
      end else begin
         out_data[15:8]  = hold_ff.frame_type;
         out_data[31:16] = hold_ff.seq_num;
         out_data[47:32] = hold_ff.length;
         out_data[55:48] = hold_ff.flags;
         out_data[57:56] = hold_ff.status;
      end
   end

endmodule
